/* src/tdcdh_pkg.sv */
// types and constants shared by the tdc dither linearising histogram
// no dependencies
`timescale 1ns / 1ps

package tdcdh_pkg;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_PHOTON = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [1:0] REG_FIRST_CODE  = 2'd0;
	localparam logic [1:0] REG_LAST_CODE   = 2'd1;
	localparam logic [1:0] REG_INV_WIDTH   = 2'd2;
	localparam logic [1:0] REG_PEAK_OFFSET = 2'd3;

	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [27:0] START_MAX = 28'hFFF_FFFF;
	localparam logic [12:0] END_NONE  = 13'h1FFF;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] code;
		logic [15:0] width_value;
		logic [11:0] out_bin;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic [11:0] bin_index;
		logic [31:0] count;
	} out_item_t;

	typedef struct packed {
		logic [11:0]        first_code;
		logic [12:0]        last_code;
		logic [23:0]        inverse_bin_width;
		logic signed [20:0] peak_offset;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_PHOTON,
		CMD_READ
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [11:0] code;
		logic [11:0] out_bin;
		logic [15:0] width_value;
		logic [31:0] frac;
		logic [27:0] start;
		logic [27:0] next_start;
	} cmd_entry_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_TABLE,
		B_TIME,
		B_MUL,
		B_SUM,
		B_MAP,
		B_HIST,
		B_RDH,
		B_OUT
	} back_state_t;

endpackage

/* src/tdcdh_front.sv */
// front end: accepts items, range checks, advances dither lfsr and running start
// depends on tdcdh_pkg
`timescale 1ns / 1ps

module tdcdh_front #(
	parameter int NUM_CODES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tdcdh_pkg::cfg_t      cfg,
	input  logic                 push,
	input  tdcdh_pkg::in_item_t  sample,
	output logic                 full,
	input  logic                 q_full,
	input  logic                 clearing,
	output logic                 q_push,
	output tdcdh_pkg::cmd_entry_t q_entry
);

	localparam logic [16:0] NCODES = 17'(NUM_CODES);

	logic [31:0] lfsr_q;
	logic [27:0] rs_q;
	logic [31:0] lfsr_nx;
	logic        code_ok;
	logic [28:0] sum;

	assign full   = q_full | clearing;
	assign q_push = push & ~full;
	assign code_ok = {5'd0, sample.code} < NCODES;

	always_comb begin
		lfsr_nx = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? tdcdh_pkg::LFSR_TAPS : 32'd0);
		q_entry.code        = sample.code;
		q_entry.out_bin     = sample.out_bin;
		q_entry.width_value = sample.width_value;
		q_entry.frac        = lfsr_nx;
		q_entry.start       = (sample.code == cfg.first_code) ? 28'd0 : rs_q;
		sum = {1'b0, q_entry.start} + {13'd0, sample.width_value};
		q_entry.next_start = (sum > {1'b0, tdcdh_pkg::START_MAX}) ?
			tdcdh_pkg::START_MAX : sum[27:0];
		case (sample.action)
			tdcdh_pkg::ACT_LOAD: begin
				q_entry.cmd = code_ok ? tdcdh_pkg::CMD_LOAD : tdcdh_pkg::CMD_NONE;
			end
			tdcdh_pkg::ACT_PHOTON: begin
				q_entry.cmd = (code_ok && sample.code >= cfg.first_code &&
					{1'b0, sample.code} < cfg.last_code) ?
					tdcdh_pkg::CMD_PHOTON : tdcdh_pkg::CMD_NONE;
			end
			tdcdh_pkg::ACT_READ: begin
				q_entry.cmd = tdcdh_pkg::CMD_READ;
			end
			default: begin
				q_entry.cmd = tdcdh_pkg::CMD_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= '1;
			rs_q   <= '0;
		end else if (q_push) begin
			if (q_entry.cmd == tdcdh_pkg::CMD_PHOTON) begin
				lfsr_q <= lfsr_nx;
			end
			if (q_entry.cmd == tdcdh_pkg::CMD_LOAD) begin
				rs_q <= q_entry.next_start;
			end
		end
	end

endmodule

/* src/tdcdh_queue.sv */
// two entry command queue between front and back
// depends on tdcdh_pkg
`timescale 1ns / 1ps

module tdcdh_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tdcdh_pkg::cmd_entry_t wr_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output tdcdh_pkg::cmd_entry_t head
);

	tdcdh_pkg::cmd_entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* src/tdcdh_back.sv */
// back end: code tables, bin mapping, histogram memory and result register
// depends on tdcdh_pkg
`timescale 1ns / 1ps

module tdcdh_back #(
	parameter int NUM_CODES    = 4096,
	parameter int NUM_OUT_BINS = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tdcdh_pkg::cfg_t       cfg,
	input  logic                  q_valid,
	input  tdcdh_pkg::cmd_entry_t head,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  empty,
	input  logic                  pop,
	output tdcdh_pkg::out_item_t  result
);

	localparam int CAW = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
	localparam int BAW = (NUM_OUT_BINS > 1) ? $clog2(NUM_OUT_BINS) : 1;
	localparam logic [16:0] NBINS = 17'(NUM_OUT_BINS);
	localparam logic [BAW-1:0] LAST_BIN = BAW'(NUM_OUT_BINS - 1);

	logic [15:0] width_mem [NUM_CODES];
	logic [27:0] start_mem [NUM_CODES];
	logic [31:0] hist_mem  [NUM_OUT_BINS];

	tdcdh_pkg::back_state_t state_q, state_nx;
	tdcdh_pkg::cmd_entry_t  cur_q;
	tdcdh_pkg::out_item_t   res_q;
	tdcdh_pkg::out_item_t   out_q;
	logic                   out_valid_q;
	logic [BAW-1:0]         clr_q;
	logic [12:0]            end_bin_q;

	logic [15:0] wd_rd_q;
	logic [27:0] st_rd_q;
	logic [31:0] hist_rd_q;
	logic [47:0] dith_q;
	logic [36:0] t_q;
	logic [42:0] plo_q;
	logic [41:0] phi_q;
	logic [60:0] prod_q;
	logic [15:0] bin_q;

	logic [62:0] s;
	logic [29:0] map_bin;
	logic        map_ok;
	logic        map_hit;
	logic [16:0] head_code17;
	logic [CAW-1:0] code_addr;
	logic [15:0] head_ob16;
	logic [15:0] cur_ob16;
	logic [15:0] map_bin16;
	logic        cur_ob_ok;
	logic [BAW-1:0] hist_raddr;
	logic [BAW-1:0] hist_waddr;
	logic [31:0]    hist_wdata;
	logic           hist_we;
	logic           tbl_we;
	logic           out_free;

	assign head_code17 = {5'd0, head.code};
	assign code_addr   = head_code17[CAW-1:0];
	assign head_ob16   = {4'd0, head.out_bin};
	assign cur_ob16    = {4'd0, cur_q.out_bin};
	assign cur_ob_ok   = {5'd0, cur_q.out_bin} < NBINS;
	assign out_free    = ~out_valid_q | pop;
	assign clearing    = state_q == tdcdh_pkg::B_CLEAR;
	assign empty       = ~out_valid_q;
	assign result      = out_q;

	// signed offset with 8 fraction bits of a bin, aligned to the Q.32 scaled time and added to it
	always_comb begin
		s = {2'b00, prod_q} + {{18{cfg.peak_offset[20]}}, cfg.peak_offset, 24'd0};
		map_bin   = s[61:32];
		map_ok    = ~s[62] && map_bin < {13'd0, NBINS};
		map_hit   = map_ok && map_bin != {17'd0, end_bin_q};
		map_bin16 = map_bin[15:0];
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tdcdh_pkg::B_CLEAR: begin
				if (clr_q == LAST_BIN) begin
					state_nx = tdcdh_pkg::B_IDLE;
				end
			end
			tdcdh_pkg::B_IDLE: begin
				if (q_valid) begin
					case (head.cmd)
						tdcdh_pkg::CMD_LOAD, tdcdh_pkg::CMD_PHOTON: begin
							state_nx = tdcdh_pkg::B_TABLE;
						end
						tdcdh_pkg::CMD_READ: begin
							state_nx = tdcdh_pkg::B_RDH;
						end
						default: begin
							state_nx = tdcdh_pkg::B_OUT;
						end
					endcase
				end
			end
			tdcdh_pkg::B_TABLE: state_nx = tdcdh_pkg::B_TIME;
			tdcdh_pkg::B_TIME:  state_nx = tdcdh_pkg::B_MUL;
			tdcdh_pkg::B_MUL:   state_nx = tdcdh_pkg::B_SUM;
			tdcdh_pkg::B_SUM:   state_nx = tdcdh_pkg::B_MAP;
			tdcdh_pkg::B_MAP: begin
				if (cur_q.cmd == tdcdh_pkg::CMD_PHOTON && map_hit) begin
					state_nx = tdcdh_pkg::B_HIST;
				end else begin
					state_nx = tdcdh_pkg::B_OUT;
				end
			end
			tdcdh_pkg::B_HIST: state_nx = tdcdh_pkg::B_OUT;
			tdcdh_pkg::B_RDH:  state_nx = tdcdh_pkg::B_OUT;
			tdcdh_pkg::B_OUT: begin
				if (out_free) begin
					state_nx = tdcdh_pkg::B_IDLE;
				end
			end
			default: state_nx = tdcdh_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = (state_q == tdcdh_pkg::B_IDLE) && q_valid;
		tbl_we     = q_pop && head.cmd == tdcdh_pkg::CMD_LOAD;
		hist_raddr = (state_q == tdcdh_pkg::B_MAP) ? map_bin16[BAW-1:0] :
			head_ob16[BAW-1:0];
		hist_we    = 1'b0;
		hist_waddr = clr_q;
		hist_wdata = '0;
		case (state_q)
			tdcdh_pkg::B_CLEAR: begin
				hist_we = 1'b1;
			end
			tdcdh_pkg::B_RDH: begin
				hist_we    = cur_ob_ok;
				hist_waddr = cur_ob16[BAW-1:0];
			end
			tdcdh_pkg::B_HIST: begin
				hist_we    = 1'b1;
				hist_waddr = bin_q[BAW-1:0];
				hist_wdata = (hist_rd_q == '1) ? hist_rd_q : hist_rd_q + 32'd1;
			end
			default: begin
				hist_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			width_mem[code_addr] <= head.width_value;
			start_mem[code_addr] <= head.start;
		end
		if (q_pop) begin
			wd_rd_q <= width_mem[code_addr];
			st_rd_q <= start_mem[code_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rd_q <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= head;
			res_q <= '0;
		end
		dith_q <= wd_rd_q * cur_q.frac;
		if (cur_q.cmd == tdcdh_pkg::CMD_LOAD) begin
			t_q <= {1'b0, cur_q.next_start, 8'd0};
		end else begin
			t_q <= {1'b0, st_rd_q, 8'd0} + {13'd0, dith_q[47:24]};
		end
		plo_q  <= t_q[18:0] * cfg.inverse_bin_width;
		phi_q  <= t_q[36:19] * cfg.inverse_bin_width;
		prod_q <= {phi_q, 19'd0} + {18'd0, plo_q};
		if (state_q == tdcdh_pkg::B_MAP) begin
			bin_q <= map_bin16;
		end
		if (state_q == tdcdh_pkg::B_HIST) begin
			res_q.accepted  <= 1'b1;
			res_q.bin_index <= bin_q[11:0];
		end
		if (state_q == tdcdh_pkg::B_RDH) begin
			res_q.count <= cur_ob_ok ? hist_rd_q : 32'd0;
		end
		if (state_q == tdcdh_pkg::B_OUT && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdcdh_pkg::B_CLEAR;
			clr_q       <= '0;
			end_bin_q   <= tdcdh_pkg::END_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == tdcdh_pkg::B_CLEAR) begin
				clr_q <= clr_q + BAW'(1);
			end
			if (state_q == tdcdh_pkg::B_MAP && cur_q.cmd == tdcdh_pkg::CMD_LOAD) begin
				end_bin_q <= (map_ok && map_bin < 30'(tdcdh_pkg::END_NONE)) ?
					map_bin[12:0] : tdcdh_pkg::END_NONE;
			end
			if (state_q == tdcdh_pkg::B_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == tdcdh_pkg::B_IDLE)
		else $error("queue pop outside idle");

	a_hist_photon: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tdcdh_pkg::B_HIST |-> cur_q.cmd == tdcdh_pkg::CMD_PHOTON)
		else $error("histogram increment without photon");

	a_rose_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == tdcdh_pkg::B_OUT)
		else $error("result appeared outside output state");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tdcdh_pkg::B_CLEAR |-> !out_valid_q && !q_pop)
		else $error("activity during clearing pass");

endmodule

/* src/tdc_dither_linearizing_histogram_core.sv */
// tdc dither linearising histogram, top level with configuration registers
// depends on tdcdh_pkg, tdcdh_front, tdcdh_queue, tdcdh_back
`timescale 1ns / 1ps

// usage
//   input side is a queue: drive sample and push; transfer when push and not full.
//   action load writes one code width (ascending order), photon bins one event,
//   read returns a bin count and clears it. every item gives one result.
//   result side is a queue: result valid while empty is low, transfer on pop.
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, ready always
//   high; write only while the block is idle.
// sequencing
//   the back sequencer handles one item at a time and pops the next only in
//   idle. unused or out-of-range items go straight to output, read through the
//   histogram read, load through table read, time, split multiply, sum and map,
//   photon also through the histogram read-modify-write when it hits a bin.
// reset
//   the histogram is cleared one bin a cycle, all NUM_OUT_BINS bins, after
//   reset; full stays high meanwhile. configuration writes are taken anyway.
// stall
//   a result not popped holds the back end; the two entry queue and full then
//   stall the input side.
module tdc_dither_linearizing_histogram_core #(
	parameter int NUM_CODES    = 4096,
	parameter int NUM_OUT_BINS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  tdcdh_pkg::in_item_t  sample,
	output logic                 empty,
	input  logic                 pop,
	output tdcdh_pkg::out_item_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data
);

	tdcdh_pkg::cfg_t       cfg_q;
	tdcdh_pkg::cmd_entry_t q_wr;
	tdcdh_pkg::cmd_entry_t q_head;
	logic                  q_push;
	logic                  q_full;
	logic                  q_pop;
	logic                  q_valid;
	logic                  clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_code        <= 12'd0;
			cfg_q.last_code         <= 13'd4096;
			cfg_q.inverse_bin_width <= 24'd65536;
			cfg_q.peak_offset       <= 21'sd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tdcdh_pkg::REG_FIRST_CODE:  cfg_q.first_code        <= cfg_data[11:0];
				tdcdh_pkg::REG_LAST_CODE:   cfg_q.last_code         <= cfg_data[12:0];
				tdcdh_pkg::REG_INV_WIDTH:   cfg_q.inverse_bin_width <= cfg_data;
				tdcdh_pkg::REG_PEAK_OFFSET: cfg_q.peak_offset       <= cfg_data[20:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	tdcdh_front #(
		.NUM_CODES(NUM_CODES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.sample   (sample),
		.full     (full),
		.q_full   (q_full),
		.clearing (clearing),
		.q_push   (q_push),
		.q_entry  (q_wr)
	);

	tdcdh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (q_wr),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	tdcdh_back #(
		.NUM_CODES    (NUM_CODES),
		.NUM_OUT_BINS (NUM_OUT_BINS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.head     (q_head),
		.q_pop    (q_pop),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

/* tb/sv/tdc_dither_linearizing_histogram_core_test.sv */
// testbench for the tdc dither linearising histogram core: a directed table, then random
// load, photon and read traffic under several register settings, checked against a predictor
// depends on tdcdh_pkg and tdc_dither_linearizing_histogram_core
`timescale 1ns / 1ps

module tdc_dither_linearizing_histogram_core_test;

	localparam int NCODE = 4096;
	localparam int NBIN  = 4096;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		tdcdh_pkg::in_item_t  item;
		bit                   typed;
		tdcdh_pkg::out_item_t want;
	} dir_row_t;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      push = 0;
	logic      full;
	tdcdh_pkg::in_item_t  sample = '0;
	logic      empty;
	logic      pop = 0;
	tdcdh_pkg::out_item_t result;
	logic      cfg_valid = 0;
	logic      cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	tdc_dither_linearizing_histogram_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [15:0] width_tab [NCODE];
	logic [27:0] start_tab [NCODE];
	bit          loaded [NCODE];
	logic [27:0] run_start;
	logic [12:0] end_bin;
	logic [31:0] hist [NBIN];
	logic [31:0] lfsr;
	tdcdh_pkg::cfg_t cfg;

	tdcdh_pkg::out_item_t pending_q [$];
	int        mismatches = 0;
	int        hold_cycles = 0;
	bit        hold_req = 0;
	int        pat_cnt = 0;
	longint    cycles = 0;

	function automatic bit time_to_bin(input logic [63:0] t16, output logic [63:0] bin);
		logic [63:0] prod;
		logic [63:0] mag;
		prod = t16 * {40'd0, cfg.inverse_bin_width};
		if (cfg.peak_offset < 0) begin
			mag = 64'(-64'(cfg.peak_offset)) << 24;
			if (prod < mag)
				return 0;
			prod = prod - mag;
		end else begin
			prod = prod + (64'(cfg.peak_offset) << 24);
		end
		bin = prod >> 32;
		return 1;
	endfunction

	function automatic tdcdh_pkg::out_item_t predict_histogram(input tdcdh_pkg::in_item_t it);
		tdcdh_pkg::out_item_t r;
		logic [28:0] sum;
		logic [63:0] bin;
		logic [63:0] t16;
		r = '0;
		case (it.action)
			tdcdh_pkg::ACT_LOAD: begin
				if (it.code == cfg.first_code)
					run_start = '0;
				width_tab[it.code] = it.width_value;
				start_tab[it.code] = run_start;
				loaded[it.code] = 1;
				sum = {1'b0, run_start} + 29'(it.width_value);
				run_start = (sum > 29'(tdcdh_pkg::START_MAX)) ? tdcdh_pkg::START_MAX :
					sum[27:0];
				if (time_to_bin(64'(run_start) << 8, bin) && bin < NBIN)
					end_bin = bin[12:0];
				else
					end_bin = tdcdh_pkg::END_NONE;
			end
			tdcdh_pkg::ACT_PHOTON: begin
				if (it.code >= cfg.first_code && 13'(it.code) < cfg.last_code) begin
					lfsr = lfsr[0] ? ((lfsr >> 1) ^ tdcdh_pkg::LFSR_TAPS) : (lfsr >> 1);
					t16 = (64'(start_tab[it.code]) << 8) +
						((64'(width_tab[it.code]) * 64'(lfsr)) >> 24);
					if (time_to_bin(t16, bin) && bin < NBIN && bin != 64'(end_bin)) begin
						if (hist[bin] != '1)
							hist[bin]++;
						r.accepted = 1;
						r.bin_index = bin[11:0];
					end
				end
			end
			tdcdh_pkg::ACT_READ: begin
				r.count = hist[it.out_bin];
				hist[it.out_bin] = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(input tdcdh_pkg::in_item_t it, input bit typed,
			input tdcdh_pkg::out_item_t want);
		tdcdh_pkg::out_item_t r;
		sample <= it;
		push <= 1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		r = predict_histogram(it);
		pending_q.push_back(typed ? want : r);
	endtask

	task automatic pause_sender(input int n);
		push <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_results();
		push <= 0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (14) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			tdcdh_pkg::REG_FIRST_CODE:  cfg.first_code = val[11:0];
			tdcdh_pkg::REG_LAST_CODE:   cfg.last_code = val[12:0];
			tdcdh_pkg::REG_INV_WIDTH:   cfg.inverse_bin_width = val;
			tdcdh_pkg::REG_PEAK_OFFSET: cfg.peak_offset = val[20:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [11:0] fc, input logic [12:0] lc,
			input logic [23:0] iw, input logic signed [20:0] po);
		write_reg(tdcdh_pkg::REG_FIRST_CODE, 24'(fc));
		write_reg(tdcdh_pkg::REG_LAST_CODE, 24'(lc));
		write_reg(tdcdh_pkg::REG_INV_WIDTH, iw);
		write_reg(tdcdh_pkg::REG_PEAK_OFFSET, {3'b0, po});
		cfg_valid <= 0;
	endtask

	function automatic tdcdh_pkg::in_item_t mk(input logic [1:0] a, input logic [11:0] c,
			input logic [15:0] w, input logic [11:0] b);
		tdcdh_pkg::in_item_t it;
		it.action = a;
		it.code = c;
		it.width_value = w;
		it.out_bin = b;
		return it;
	endfunction

	function automatic tdcdh_pkg::in_item_t random_item();
		int sel;
		int tries;
		logic [11:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			for (tries = 0; tries < 16; tries++) begin
				c = 12'($urandom_range(0, NCODE - 1));
				if (cfg.last_code > 13'(cfg.first_code))
					c = 12'($urandom_range(cfg.first_code, int'(cfg.last_code) - 1));
				if (loaded[c] || c < cfg.first_code || 13'(c) >= cfg.last_code)
					return mk(tdcdh_pkg::ACT_PHOTON, c, 16'($urandom), 12'($urandom));
			end
		end
		if (sel < 70) begin
			if (cfg.first_code > 0)
				return mk(tdcdh_pkg::ACT_PHOTON,
					12'($urandom_range(0, cfg.first_code - 1)),
					16'($urandom), 12'($urandom));
			if (cfg.last_code < 13'(NCODE))
				return mk(tdcdh_pkg::ACT_PHOTON,
					12'($urandom_range(cfg.last_code, NCODE - 1)),
					16'($urandom), 12'($urandom));
		end
		if (sel < 88)
			return mk(tdcdh_pkg::ACT_READ, 12'($urandom), 16'($urandom),
				($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 200)));
		if (sel < 95)
			return mk(tdcdh_pkg::ACT_LOAD, 12'($urandom), 16'($urandom), 12'($urandom));
		return mk(ACT_NONE, 12'($urandom), 16'($urandom), 12'($urandom));
	endfunction

	// random traffic in bursts, starting with an ascending width load
	task automatic run_phase(input int n_items, input int n_loads, input int wmax);
		int left;
		int burst;
		int k;
		for (k = 0; k < n_loads && cfg.first_code + k < NCODE; k++)
			send_item(mk(tdcdh_pkg::ACT_LOAD, 12'(cfg.first_code + k),
				16'($urandom_range(0, wmax)), 12'($urandom)), 0, '0);
		left = n_items;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && left > 0) begin
				send_item(random_item(), 0, '0);
				burst--;
				left--;
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 8));
		end
	endtask

	// receiver: check, then pop on a changing pattern or hold off
	always @(posedge clk) begin
		tdcdh_pkg::out_item_t want;
		cycles <= cycles + 1;
		if (pop && !empty) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				want = pending_q.pop_front();
				if (result.accepted !== want.accepted || result.bin_index !== want.bin_index ||
						result.count !== want.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected acc %b bin %0d count %0d, %s %b %0d %0d",
							want.accepted, want.bin_index, want.count, "got acc bin count",
							result.accepted, result.bin_index, result.count);
				end
			end
		end
		pat_cnt++;
		if (hold_req) begin
			hold_req = 0;
			hold_cycles = 400;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			pop <= 0;
		end else begin
			case ((pat_cnt >> 6) % 3)
				0: pop <= 1;
				1: pop <= $urandom_range(0, 1);
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (cycles > 2000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		dir_row_t tab [$];
		int i;
		for (i = 0; i < NCODE; i++) begin
			width_tab[i] = '0;
			start_tab[i] = '0;
			loaded[i] = 0;
			hist[i] = '0;
		end
		run_start = '0;
		end_bin = tdcdh_pkg::END_NONE;
		lfsr = '1;
		cfg.first_code = 0;
		cfg.last_code = 13'd4096;
		cfg.inverse_bin_width = 24'd65536;
		cfg.peak_offset = '0;

		tab.push_back('{mk(tdcdh_pkg::ACT_READ, 0, 0, 0), 1, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_READ, 12'hFFF, 16'hFFFF, 12'hFFF), 1, '0});
		tab.push_back('{mk(ACT_NONE, 12'hFFF, 16'hFFFF, 12'hFFF), 1, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_LOAD, 0, 16'd256, 0), 1, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_LOAD, 1, 16'd512, 0), 1, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_LOAD, 2, 16'hFFFF, 0), 1, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_LOAD, 3, 16'd0, 0), 1, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_LOAD, 12'hFFF, 16'hFFFF, 0), 1, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_PHOTON, 0, 0, 0), 0, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_PHOTON, 1, 0, 0), 0, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_PHOTON, 1, 0, 0), 0, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_PHOTON, 2, 0, 0), 0, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_PHOTON, 3, 0, 0), 0, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_PHOTON, 12'hFFF, 0, 0), 0, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_LOAD, 0, 16'd128, 0), 1, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_PHOTON, 0, 0, 0), 0, '0});
		for (i = 0; i < 4; i++)
			tab.push_back('{mk(tdcdh_pkg::ACT_READ, 0, 0, 12'(i)), 0, '0});
		tab.push_back('{mk(tdcdh_pkg::ACT_READ, 0, 0, 0), 1, '0});

		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (tab[k]) begin
			send_item(tab[k].item, tab[k].typed, tab[k].want);
			if (k % 5 == 4)
				pause_sender($urandom_range(1, 4));
		end
		drain_results();

		run_phase(250, 48, 1024);
		drain_results();

		set_regs(12'd100, 13'd300, 24'd196608, -21'sd1280);
		hold_req = 1;
		run_phase(250, 64, 700);
		drain_results();

		set_regs(12'd4095, 13'd4096, 24'hFFFFFF, 21'sd1048575);
		run_phase(60, 1, 65535);
		drain_results();

		set_regs(12'd0, 13'd0, 24'd0, -21'sd1048576);
		run_phase(60, 0, 100);
		drain_results();

		set_regs(12'd2000, 13'd2600, 24'd16384, 21'sd300);
		run_phase(250, 200, 4000);
		drain_results();

		set_regs(12'($urandom_range(0, 3000)), 13'd4096, 24'($urandom_range(20000, 200000)),
			-21'($urandom_range(0, 2000)));
		run_phase(250, 40, 2000);
		drain_results();

		if (mismatches == 0 && pending_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
